/* rtl/cbc_pkg.sv */
package cbc_pkg;

    // Default sizes of the bank address space
    localparam int DEF_MAX_ROM_BANKS = 512;
    localparam int DEF_MAX_RAM_BANKS = 16;

    // Fixed field widths
    localparam int ADDR_W      = 16;
    localparam int DATA_W      = 8;
    localparam int ROM_BANK_W  = 9;
    localparam int RAM_BANK_W  = 4;
    localparam int RAM_REG_W   = 8;
    localparam int PHYS_W      = 23;
    localparam int ROM_OFS_W   = 14;
    localparam int RAM_OFS_W   = 13;
    localparam int KIND_W      = 3;
    localparam int ROM_COUNT_W = 10;
    localparam int RAM_COUNT_W = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int TARGET_W    = 2;
    localparam int RESULT_W    = PHYS_W + 2 * ROM_BANK_W + RAM_BANK_W + 1;
    localparam int M_TDATA_W   = ((RESULT_W + 7) / 8) * 8;
    localparam int S_TDATA_W   = ADDR_W + DATA_W;

    // Controller generations
    localparam logic [KIND_W-1:0] KIND_MBC1 = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MBC5 = 3'd5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROLLER_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_COUNT  = 2'd2;

    // Register regions below 0x8000, selected by address bits 14:13
    localparam logic [1:0] REGION_RAM_ENABLE = 2'd0;
    localparam logic [1:0] REGION_ROM_BANK   = 2'd1;
    localparam logic [1:0] REGION_RAM_BANK   = 2'd2;
    localparam logic [1:0] REGION_MODE       = 2'd3;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;

    typedef enum logic [TARGET_W-1:0] {
        TARGET_NONE     = 2'd0,
        TARGET_ROM      = 2'd1,
        TARGET_RAM      = 2'd2,
        TARGET_OPEN_BUS = 2'd3
    } cbc_target_t;

    typedef struct packed {
        logic                   ram_enable;
        logic [ROM_BANK_W-1:0]  rom_bank;
        logic [RAM_REG_W-1:0]   ram_bank;
        logic                   banking_mode;
    } cbc_state_t;

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [ROM_COUNT_W-1:0] rom_count;
        logic [RAM_COUNT_W-1:0] ram_count;
    } cbc_cfg_t;

    typedef struct packed {
        logic                   ram_is_enabled;
        logic [RAM_BANK_W-1:0]  ram_window_bank;
        logic [ROM_BANK_W-1:0]  high_window_bank;
        logic [ROM_BANK_W-1:0]  low_window_bank;
        logic [PHYS_W-1:0]      physical_address;
    } cbc_result_t;

endpackage

/* rtl/cbc_bank_regs.sv */
module cbc_bank_regs
    import cbc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  commit,
    input  logic                  is_write,
    input  logic [ADDR_W-1:0]     bus_address,
    input  logic [DATA_W-1:0]     write_data,
    input  logic [KIND_W-1:0]     kind,
    output cbc_state_t            state_next
);

    cbc_state_t state_reg;
    logic       mbc5;
    logic [4:0] low5;

    assign mbc5 = (kind == KIND_MBC5);
    assign low5 = write_data[4:0];

    always_comb begin
        state_next = state_reg;
        if (is_write && !bus_address[15]) begin
            case (bus_address[14:13])
                REGION_RAM_ENABLE: begin
                    state_next.ram_enable = (write_data[3:0] == RAM_ENABLE_KEY);
                end
                REGION_ROM_BANK: begin
                    if (mbc5 && bus_address[12]) begin
                        state_next.rom_bank[8] = write_data[0];
                    end else if (mbc5) begin
                        state_next.rom_bank[7:0] = write_data;
                    end else if (low5 != 5'd0) begin
                        state_next.rom_bank = {4'd0, low5};
                    end else begin
                        state_next.rom_bank = ROM_BANK_W'(1);
                    end
                end
                REGION_RAM_BANK: begin
                    state_next.ram_bank = write_data;
                end
                REGION_MODE: begin
                    state_next.banking_mode = write_data[0];
                end
                default: begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.ram_enable   <= 1'b0;
            state_reg.rom_bank     <= ROM_BANK_W'(1);
            state_reg.ram_bank     <= '0;
            state_reg.banking_mode <= 1'b0;
        end else if (commit) begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/cbc_translate.sv */
module cbc_translate
    import cbc_pkg::*;
#(
    parameter int MAX_ROM_BANKS = DEF_MAX_ROM_BANKS,
    parameter int MAX_RAM_BANKS = DEF_MAX_RAM_BANKS
) (
    input  cbc_state_t         state,
    input  cbc_cfg_t           cfg,
    input  logic               is_write,
    input  logic [ADDR_W-1:0]  bus_address,
    output cbc_target_t        target,
    output cbc_result_t        result
);

    localparam logic [ROM_BANK_W-1:0] ROM_LIMIT = ROM_BANK_W'(MAX_ROM_BANKS - 1);
    localparam logic [RAM_BANK_W-1:0] RAM_LIMIT = RAM_BANK_W'(MAX_RAM_BANKS - 1);

    logic [ROM_COUNT_W-1:0] rom_count_m1;
    logic [RAM_COUNT_W-1:0] ram_count_m1;
    logic [ROM_BANK_W-1:0]  rom_mask;
    logic [RAM_BANK_W-1:0]  ram_mask;
    logic [ROM_BANK_W-1:0]  upper;
    logic                   mbc5;
    logic                   upper_used;
    logic [ROM_BANK_W-1:0]  low_bank;
    logic [ROM_BANK_W-1:0]  high_bank;
    logic [RAM_BANK_W-1:0]  ram_bank;
    logic [ROM_BANK_W-1:0]  rom_sel;

    assign rom_count_m1 = cfg.rom_count - ROM_COUNT_W'(1);
    assign ram_count_m1 = cfg.ram_count - RAM_COUNT_W'(1);
    assign rom_mask     = rom_count_m1[ROM_BANK_W-1:0] & ROM_LIMIT;
    assign ram_mask     = ram_count_m1[RAM_BANK_W-1:0] & RAM_LIMIT;

    assign mbc5       = (cfg.kind == KIND_MBC5);
    assign upper_used = (cfg.kind != KIND_MBC1) || state.banking_mode;
    assign upper      = {2'd0, state.ram_bank[1:0], 5'd0};

    assign low_bank  = (mbc5 || !upper_used) ? '0 : (upper & rom_mask);
    assign high_bank = (mbc5 ? state.rom_bank : (upper | state.rom_bank)) & rom_mask;
    assign ram_bank  = upper_used ? (state.ram_bank[RAM_BANK_W-1:0] & ram_mask) : '0;
    assign rom_sel   = bus_address[14] ? high_bank : low_bank;

    always_comb begin
        target                  = TARGET_NONE;
        result.physical_address = '0;
        result.low_window_bank  = low_bank;
        result.high_window_bank = high_bank;
        result.ram_window_bank  = ram_bank;
        result.ram_is_enabled   = state.ram_enable;
        if (!bus_address[15]) begin
            // Writes below 0x8000 only load registers and map nothing
            if (!is_write) begin
                target                  = TARGET_ROM;
                result.physical_address = {rom_sel, bus_address[ROM_OFS_W-1:0]};
            end
        end else if (bus_address inside {[16'hA000:16'hBFFF]}) begin
            if (state.ram_enable) begin
                target                  = TARGET_RAM;
                result.physical_address =
                    {6'd0, ram_bank, bus_address[RAM_OFS_W-1:0]};
            end else begin
                target = TARGET_OPEN_BUS;
            end
        end
    end

endmodule

/* rtl/cartridge_bank_controller_top.sv */
// An accepted s_ beat passes through the input register and then the result register to its m_ beat.
// Throughput: one access per cycle; the bank mapping logic between the two registers is the
//   only work, so a new beat is taken every cycle while the result side keeps up.
// Reset: aresetn is synchronous and active low; it empties both registers and sets the
//   controller to MBC1, 2 ROM banks, 1 RAM bank, RAM disabled, ROM bank 1, RAM bank 0, mode 0.
module cartridge_bank_controller_top
    import cbc_pkg::*;
#(
    parameter int MAX_ROM_BANKS = DEF_MAX_ROM_BANKS,
    parameter int MAX_RAM_BANKS = DEF_MAX_RAM_BANKS
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Access stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [15:0] bus_address, [23:16] write_data
    input  logic                  s_tuser,   // [0] mode (0 read, 1 write)

    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [22:0] physical_address,
                                             // [31:23] low_window_bank,
                                             // [40:32] high_window_bank,
                                             // [44:41] ram_window_bank,
                                             // [45] ram_is_enabled, [47:46] zero
    output logic [TARGET_W-1:0]   m_tuser,   // [1:0] target

    // Configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Input register
    logic                 in_valid_reg, in_valid_next;
    logic                 in_write_reg;
    logic [ADDR_W-1:0]    in_addr_reg;
    logic [DATA_W-1:0]    in_data_reg;

    // Result register
    logic                 out_valid_reg, out_valid_next;
    cbc_target_t          out_target_reg;
    cbc_result_t          out_result_reg;

    // Configuration registers
    cbc_cfg_t             cfg_reg;

    logic                 advance;
    cbc_state_t           state_next;
    cbc_target_t          target;
    cbc_result_t          result;

    // Move the held access into the result register when that slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Configuration must only be written while the block is idle; the block does not enforce it and always takes it
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: input fields load on accept, result fields load on advance; both hold otherwise
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_write_reg <= s_tuser;
            in_addr_reg  <= s_tdata[ADDR_W-1:0];
            in_data_reg  <= s_tdata[ADDR_W +: DATA_W];
        end
        if (advance) begin
            out_target_reg <= target;
            out_result_reg <= result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kind      <= KIND_MBC1;
            cfg_reg.rom_count <= ROM_COUNT_W'(2);
            cfg_reg.ram_count <= RAM_COUNT_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_CONTROLLER_KIND: cfg_reg.kind      <= cfg_data[KIND_W-1:0];
                CFG_ROM_BANK_COUNT:  cfg_reg.rom_count <= cfg_data[ROM_COUNT_W-1:0];
                CFG_RAM_BANK_COUNT:  cfg_reg.ram_count <= cfg_data[RAM_COUNT_W-1:0];
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    // Control registers: the next state includes this beat's register write and is
    // committed only when the beat moves on, so results report banks after the access
    cbc_bank_regs u_bank_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .commit      (advance),
        .is_write    (in_write_reg),
        .bus_address (in_addr_reg),
        .write_data  (in_data_reg),
        .kind        (cfg_reg.kind),
        .state_next  (state_next)
    );

    // Window decode and bank mapping; reads and RAM writes leave the state as it is,
    // so mapping from the next state serves every kind of access
    cbc_translate #(
        .MAX_ROM_BANKS (MAX_ROM_BANKS),
        .MAX_RAM_BANKS (MAX_RAM_BANKS)
    ) u_translate (
        .state       (state_next),
        .cfg         (cfg_reg),
        .is_write    (in_write_reg),
        .bus_address (in_addr_reg),
        .target      (target),
        .result      (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_target_reg;
    assign m_tdata  = M_TDATA_W'(out_result_reg);

endmodule
